/* rtl/assert_macros.svh */
// Assertion macros shared by the ordered list RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define OLIE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define OLIE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define OLIE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define OLIE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* rtl/olie_pkg.sv */
// Package for the ordered list block: field widths, capacity, codes and types.
// Used by the interfaces and by every module of the block.
package olie_pkg;

  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 5;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Capacity of the list and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

/* rtl/olie_if.sv */
// Request and result channel interfaces of the ordered list block.
// Depends on olie_pkg for the field widths.
interface olie_req_if import olie_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [INDEX_W-1:0]        index;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, func, index, value, input ready);
  modport sink (input valid, func, index, value, output ready);
endinterface

interface olie_rsp_if import olie_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  read_data;
  logic [COUNT_W-1:0]        count;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, read_data, count, status, input ready);
  modport sink (input valid, read_data, count, status, output ready);
endinterface

/* rtl/olie_store.sv */
// Element memory: one write port and one read port with registered read data.
// Depends on olie_pkg.
module olie_store import olie_pkg::*; (
  input  logic              clk,
  input  mem_cmd_t          cmd,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    rdata_r <= mem[cmd.raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/olie_seq.sv */
// Request sequencer: decodes a request, checks bounds and steps the shared
// address unit through the memory to move entries. Depends on olie_pkg, olie_if.
module olie_seq import olie_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  olie_req_if.sink          in_ch,
  output mem_cmd_t          mem_cmd,
  input  logic [DATA_W-1:0] rdata,
  output res_t              res,
  output logic              res_valid,
  input  logic              res_take,
  output logic [CNT_W-1:0]  cur_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RDW   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              ins_r, ins_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  res_t              res_r, res_nxt;

  logic              accept;
  logic              full;
  logic [CMP_W-1:0]  idx_w, cnt_w;
  logic [ADDR_W-1:0] in_addr, cnt_addr, last_addr;
  logic [ADDR_W-1:0] src_up, src_dn;

  assign accept   = in_ch.valid && in_ch.ready;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign idx_w    = CMP_W'(in_ch.index);
  assign cnt_w    = CMP_W'(count_r);
  assign in_addr  = ADDR_W'(in_ch.index);
  assign cnt_addr = ADDR_W'(count_r);

  // Shared address stepper, one position per cycle.
  assign src_up    = src_r + ADDR_W'(1);
  assign src_dn    = src_r - ADDR_W'(1);
  // Insert walks down to the insert position; erase walks up to the old last entry.
  assign last_addr = ins_r ? idx_r : ADDR_W'(count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ins_nxt   = ins_r;
    pend_nxt  = pend_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    mem_cmd.we    = 1'b0;
    mem_cmd.waddr = dst_r;
    mem_cmd.wdata = rdata;
    mem_cmd.raddr = src_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = in_addr;
          val_nxt   = in_ch.value;
          ins_nxt   = 1'b0;
          pend_nxt  = 1'b0;
          state_nxt = S_FIN;
          res_nxt.read_data = '0;
          res_nxt.status    = ST_OK;
          case (in_ch.func)
            FN_APPEND: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = cnt_addr;
                mem_cmd.wdata = in_ch.value;
                count_nxt     = count_r + CNT_W'(1);
              end
            end
            FN_POP: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            FN_INSERT: begin
              if (idx_w > cnt_w) begin
                res_nxt.status = ST_INDEX;
              end else if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                if (idx_w == cnt_w) begin
                  mem_cmd.we    = 1'b1;
                  mem_cmd.waddr = in_addr;
                  mem_cmd.wdata = in_ch.value;
                end else begin
                  ins_nxt   = 1'b1;
                  src_nxt   = cnt_addr - ADDR_W'(1);
                  state_nxt = S_SHIFT;
                end
              end
            end
            FN_ERASE: begin
              if (idx_w >= cnt_w) begin
                res_nxt.status = ST_INDEX;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                if (idx_w + CMP_W'(1) != cnt_w) begin
                  src_nxt   = in_addr + ADDR_W'(1);
                  state_nxt = S_SHIFT;
                end
              end
            end
            FN_READ: begin
              if (idx_w >= cnt_w) begin
                res_nxt.status = ST_INDEX;
              end else begin
                mem_cmd.raddr = in_addr;
                state_nxt     = S_RDW;
              end
            end
            FN_WRITE: begin
              if (idx_w >= cnt_w) begin
                res_nxt.status = ST_INDEX;
              end else begin
                mem_cmd.we    = 1'b1;
                mem_cmd.waddr = in_addr;
                mem_cmd.wdata = in_ch.value;
              end
            end
            default: begin
            end
          endcase
          res_nxt.count = COUNT_W'(count_nxt);
        end
      end
      S_SHIFT: begin
        // Read one entry per cycle and write the one read in the previous cycle.
        mem_cmd.we = pend_r;
        pend_nxt   = 1'b1;
        dst_nxt    = ins_r ? src_up : src_dn;
        if (src_r == last_addr) begin
          state_nxt = S_DRAIN;
        end else begin
          src_nxt = ins_r ? src_dn : src_up;
        end
      end
      S_DRAIN: begin
        mem_cmd.we = 1'b1;
        state_nxt  = ins_r ? S_PUT : S_FIN;
      end
      S_PUT: begin
        mem_cmd.we    = 1'b1;
        mem_cmd.waddr = idx_r;
        mem_cmd.wdata = val_r;
        state_nxt     = S_FIN;
      end
      S_RDW: begin
        res_nxt.read_data = rdata;
        state_nxt         = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
      ins_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
      ins_r   <= ins_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    dst_r <= dst_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign res         = res_r;
  assign res_valid   = (state_r == S_FIN);
  assign cur_count   = count_r;

endmodule

/* rtl/ordered_list_insert_erase.sv */
// Ordered list of up to DEPTH signed words: append, remove last, insert, erase, read, write.
// From the accepting edge each result passes through the sequencer's result holding state to the
// output register; a read first waits for the registered memory data, and an insert or erase
// that moves entries first steps through each moved entry, an insert then writing the new value.
// One request is in the sequencer at a time; ready returns as the result enters the output register.
// Reset (rst_n low, synchronous) empties the list; stored words are not cleared.
module ordered_list_insert_erase import olie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  olie_req_if.sink   in_ch,
  olie_rsp_if.source out_ch
);

`include "assert_macros.svh"

  // The sequencer owns the element count and drives the memory's write and read ports.
  // Each request lands in a result holding state inside the sequencer, which
  // hands it to the output register below as soon as that register is free.
  mem_cmd_t          mem_cmd;
  logic [DATA_W-1:0] rdata;
  res_t              res;
  logic              res_valid;
  logic              res_take;
  logic [CNT_W-1:0]  cur_count;

  olie_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .mem_cmd   (mem_cmd),
    .rdata     (rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take),
    .cur_count (cur_count)
  );

  // The element memory. Only entries below the count are ever read, and each
  // of those has been written by an earlier request.
  olie_store u_store (
    .clk   (clk),
    .cmd   (mem_cmd),
    .rdata (rdata)
  );

  // Output register: it frees the sequencer to accept the next request while
  // a finished result still waits for the consumer.
  logic out_valid_r, out_valid_nxt;
  res_t out_r;

  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_r.read_data;
  assign out_ch.count     = out_r.count;
  assign out_ch.status    = out_r.status;

  // The count never passes the capacity.
  `OLIE_ASSERT_ALWAYS(a_count_cap, clk, rst_n, cur_count <= CNT_W'(DEPTH), "count above capacity")
  // A full rejection is only ever reported with the list at capacity.
  logic full_ok;
  assign full_ok = !(out_valid_r && out_ch.status == ST_FULL) || out_ch.count == COUNT_W'(DEPTH);
  `OLIE_ASSERT_ALWAYS(a_full_count, clk, rst_n, full_ok, "full status with room left")
  // Every accept moves the sequencer out of its idle state, so ready drops after an accept.
  logic in_accept;
  assign in_accept = in_ch.valid && in_ch.ready;
  `OLIE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, !in_ch.ready, "ready held after accept")

endmodule
